@@ rtl/pps_pkg.sv @@
`timescale 1ns / 1ps
package pps_pkg;

    localparam int ID_W    = 8;
    localparam int PRIO_W  = 8;
    localparam int TIME_W  = 16;
    localparam int COUNT_W = 5;

    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_ARRIVAL = 1'b1;

    typedef struct packed {
        logic              command;
        logic [ID_W-1:0]   proc_id;
        logic [PRIO_W-1:0] proc_priority;
        logic [TIME_W-1:0] burst_time;
    } in_item_t;

    typedef struct packed {
        logic               run_valid;
        logic [ID_W-1:0]    run_id;
        logic [PRIO_W-1:0]  run_priority;
        logic [TIME_W-1:0]  run_time_left;
        logic               arrival_dropped;
        logic [COUNT_W-1:0] ready_count;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_START,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_TICK_SEL,
        ST_TAKE,
        ST_PRE_RD,
        ST_PRE_CHK,
        ST_DEC,
        ST_FINISH
    } state_t;

endpackage

@@ rtl/pps_stream_if.sv @@
`timescale 1ns / 1ps
interface pps_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/pps_table.sv @@
`timescale 1ns / 1ps
module pps_table #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

@@ rtl/preemptive_priority_scheduler_unit.sv @@
`timescale 1ns / 1ps
// Preemptive priority scheduler. Each beat on req is either a tick or a process arrival, and
// each produces exactly one beat on result describing the runner and the ready table after it.
// The ready table lives in a single-port-write, registered-read memory kept sorted with the
// most urgent entry at the top address, so taking the head is one read and one decrement.
// An arrival passes each table entry of equal or higher priority, moving it up one slot, on
// its walk down from the top address; a tick that preempts the runner adds the reinsertion of
// the runner. The insertion walk moves one entry per cycle through the table memory. A finished
// result sits in an output register, so the next beat is accepted while it waits to be taken.
module preemptive_priority_scheduler_unit #(
    parameter int READY_DEPTH   = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int TIME_BITS     = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    pps_stream_if.sink   req,
    pps_stream_if.source result
);
    localparam int AW = $clog2(READY_DEPTH);
    localparam int CW = $clog2(READY_DEPTH + 1);
    localparam int EW = pps_pkg::ID_W + PRIORITY_BITS + TIME_BITS;
    localparam logic [CW-1:0] FULL_COUNT = CW'(READY_DEPTH);

    pps_pkg::state_t state_reg, state_next;

    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            k_reg, k_next;
    logic                     is_tick_reg, is_tick_next;
    logic                     dropped_reg, dropped_next;
    logic [EW-1:0]            ins_reg, ins_next;
    logic                     run_valid_reg, run_valid_next;
    logic [pps_pkg::ID_W-1:0] run_id_reg, run_id_next;
    logic [PRIORITY_BITS-1:0] run_prio_reg, run_prio_next;
    logic [TIME_BITS-1:0]     run_time_reg, run_time_next;
    logic                     out_valid_reg, out_valid_next;
    pps_pkg::out_item_t       out_reg, out_next;

    logic          tbl_we;
    logic [AW-1:0] tbl_waddr;
    logic [EW-1:0] tbl_wdata;
    logic          tbl_re;
    logic [AW-1:0] tbl_raddr;
    logic [EW-1:0] tbl_rdata;

    logic                     in_fire;
    logic                     need_take;
    logic                     out_free;
    logic [AW-1:0]            top_addr;
    logic [PRIORITY_BITS-1:0] rd_prio;
    logic [PRIORITY_BITS-1:0] ins_prio;
    logic [PRIORITY_BITS-1:0] cmp_a;
    logic [PRIORITY_BITS-1:0] cmp_b;
    logic                     cmp_lt;

    pps_table #(
        .DEPTH (READY_DEPTH),
        .WIDTH (EW)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    assign in_fire   = req.valid && req.ready;
    assign req.ready = (state_reg == pps_pkg::ST_IDLE);
    assign need_take = !run_valid_reg || (run_time_reg == '0);
    assign out_free  = !out_valid_reg || result.ready;
    assign top_addr  = AW'(count_reg - CW'(1));
    assign rd_prio   = tbl_rdata[TIME_BITS +: PRIORITY_BITS];
    assign ins_prio  = ins_reg[TIME_BITS +: PRIORITY_BITS];

    // shared priority comparator: insertion walk asks "entry below new one", preemption asks
    // "runner below table head"
    assign cmp_a  = (state_reg == pps_pkg::ST_PRE_CHK) ? run_prio_reg : rd_prio;
    assign cmp_b  = (state_reg == pps_pkg::ST_PRE_CHK) ? rd_prio : ins_prio;
    assign cmp_lt = (cmp_a < cmp_b);

    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pps_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (req.payload.command == pps_pkg::CMD_ARRIVAL)
                    begin
                        state_next = (count_reg == FULL_COUNT) ? pps_pkg::ST_FINISH
                                                               : pps_pkg::ST_INS_START;
                    end
                    else
                    begin
                        state_next = pps_pkg::ST_TICK_SEL;
                    end
                end
            end
            pps_pkg::ST_INS_START:
            begin
                state_next = (count_reg == '0) ? pps_pkg::ST_INS_PUT : pps_pkg::ST_INS_CMP;
            end
            pps_pkg::ST_INS_CMP:
            begin
                if (!cmp_lt)
                begin
                    state_next = (k_reg >= CW'(2)) ? pps_pkg::ST_INS_CMP : pps_pkg::ST_INS_PUT;
                end
                else
                begin
                    state_next = is_tick_reg ? pps_pkg::ST_DEC : pps_pkg::ST_FINISH;
                end
            end
            pps_pkg::ST_INS_PUT:
            begin
                state_next = is_tick_reg ? pps_pkg::ST_DEC : pps_pkg::ST_FINISH;
            end
            pps_pkg::ST_TICK_SEL:
            begin
                if (need_take)
                begin
                    state_next = (count_reg != '0) ? pps_pkg::ST_TAKE : pps_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = pps_pkg::ST_PRE_RD;
                end
            end
            pps_pkg::ST_TAKE:
            begin
                state_next = pps_pkg::ST_PRE_RD;
            end
            pps_pkg::ST_PRE_RD:
            begin
                state_next = (count_reg != '0) ? pps_pkg::ST_PRE_CHK : pps_pkg::ST_DEC;
            end
            pps_pkg::ST_PRE_CHK:
            begin
                state_next = cmp_lt ? pps_pkg::ST_INS_START : pps_pkg::ST_DEC;
            end
            pps_pkg::ST_DEC:
            begin
                state_next = pps_pkg::ST_FINISH;
            end
            pps_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = pps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pps_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        k_next         = k_reg;
        is_tick_next   = is_tick_reg;
        dropped_next   = dropped_reg;
        ins_next       = ins_reg;
        run_valid_next = run_valid_reg;
        run_id_next    = run_id_reg;
        run_prio_next  = run_prio_reg;
        run_time_next  = run_time_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result.ready;
        tbl_we         = 1'b0;
        tbl_waddr      = '0;
        tbl_wdata      = ins_reg;
        tbl_re         = 1'b0;
        tbl_raddr      = top_addr;

        unique case (state_reg)
            pps_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    is_tick_next = (req.payload.command == pps_pkg::CMD_TICK);
                    dropped_next = (req.payload.command == pps_pkg::CMD_ARRIVAL)
                                   && (count_reg == FULL_COUNT);
                    ins_next     = {req.payload.proc_id,
                                    PRIORITY_BITS'(req.payload.proc_priority),
                                    TIME_BITS'(req.payload.burst_time)};
                end
            end
            pps_pkg::ST_INS_START:
            begin
                k_next = count_reg;
                tbl_re = (count_reg != '0);
            end
            pps_pkg::ST_INS_CMP:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = AW'(k_reg);
                if (!cmp_lt)
                begin
                    // entry at or above the new priority moves up one slot, look one further down
                    tbl_wdata = tbl_rdata;
                    k_next    = k_reg - CW'(1);
                    tbl_re    = (k_reg >= CW'(2));
                    tbl_raddr = AW'(k_reg - CW'(2));
                end
                else
                begin
                    tbl_wdata  = ins_reg;
                    count_next = count_reg + CW'(1);
                end
            end
            pps_pkg::ST_INS_PUT:
            begin
                tbl_we     = 1'b1;
                tbl_waddr  = AW'(k_reg);
                tbl_wdata  = ins_reg;
                count_next = count_reg + CW'(1);
            end
            pps_pkg::ST_TICK_SEL:
            begin
                if (need_take)
                begin
                    if (count_reg != '0)
                    begin
                        tbl_re = 1'b1;
                    end
                    else
                    begin
                        run_valid_next = 1'b0;
                        run_id_next    = '0;
                        run_prio_next  = '0;
                        run_time_next  = '0;
                    end
                end
            end
            pps_pkg::ST_TAKE:
            begin
                run_valid_next = 1'b1;
                run_id_next    = tbl_rdata[EW-1 -: pps_pkg::ID_W];
                run_prio_next  = rd_prio;
                run_time_next  = tbl_rdata[TIME_BITS-1:0];
                count_next     = count_reg - CW'(1);
            end
            pps_pkg::ST_PRE_RD:
            begin
                tbl_re = (count_reg != '0);
            end
            pps_pkg::ST_PRE_CHK:
            begin
                if (cmp_lt)
                begin
                    // head leaves the table, runner goes back in through the insertion walk
                    ins_next      = {run_id_reg, run_prio_reg, run_time_reg};
                    run_id_next   = tbl_rdata[EW-1 -: pps_pkg::ID_W];
                    run_prio_next = rd_prio;
                    run_time_next = tbl_rdata[TIME_BITS-1:0];
                    count_next    = count_reg - CW'(1);
                end
            end
            pps_pkg::ST_DEC:
            begin
                if (run_time_reg != '0)
                begin
                    run_time_next = run_time_reg - TIME_BITS'(1);
                end
            end
            pps_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_next.run_valid       = run_valid_reg;
                    out_next.run_id          = run_id_reg;
                    out_next.run_priority    = pps_pkg::PRIO_W'(run_prio_reg);
                    out_next.run_time_left   = pps_pkg::TIME_W'(run_time_reg);
                    out_next.arrival_dropped = dropped_reg;
                    out_next.ready_count     = pps_pkg::COUNT_W'(count_reg);
                end
            end
            default:
            begin
                tbl_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pps_pkg::ST_IDLE;
            count_reg     <= '0;
            is_tick_reg   <= 1'b0;
            dropped_reg   <= 1'b0;
            run_valid_reg <= 1'b0;
            run_id_reg    <= '0;
            run_prio_reg  <= '0;
            run_time_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            is_tick_reg   <= is_tick_next;
            dropped_reg   <= dropped_next;
            run_valid_reg <= run_valid_next;
            run_id_reg    <= run_id_next;
            run_prio_reg  <= run_prio_next;
            run_time_reg  <= run_time_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        ins_reg <= ins_next;
        out_reg <= out_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("ready table count above depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == $past(count_reg)
                  || count_reg == $past(count_reg) + CW'(1)
                  || count_reg == $past(count_reg) - CW'(1)))
        else $error("ready table count moved by more than one");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pps_pkg::ST_IDLE || state_reg == pps_pkg::ST_FINISH) |-> !tbl_we)
        else $error("table written outside an operation");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.payload.arrival_dropped)
        |-> (result.payload.ready_count == pps_pkg::COUNT_W'(READY_DEPTH)))
        else $error("arrival dropped with room in the table");

    a_idle_runner_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.payload.run_valid)
        |-> (result.payload.run_id == '0 && result.payload.run_time_left == '0
             && result.payload.run_priority == '0))
        else $error("no runner but runner fields not cleared");

endmodule
